// ----- hdl/pcm_pkg.sv -----
`timescale 1ns / 1ps

package pcm_pkg;

  // Channel and field geometry
  localparam int NUM_CH   = 8;
  localparam int CH_W     = 3;
  localparam int CNT_W    = 24;
  localparam int TS_W     = 32;
  localparam int HOLD_W   = 16;
  localparam int WIN_W    = 16;
  localparam int LVL_W    = 8;
  localparam int BITS_W   = 16;
  localparam int MAP_W    = 4;
  localparam int NCH_W    = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TS_W-1:0]  ALL_ONES  = '1;

  // Register reset values
  localparam logic [NCH_W-1:0]  RST_CHANNEL_COUNT = 4'd0;
  localparam logic [CNT_W-1:0]  RST_LOG_EDGES     = 24'd20;
  localparam logic [CNT_W-1:0]  RST_FAULT_EDGES   = 24'd100;
  localparam logic [HOLD_W-1:0] RST_FAULT_HOLD    = 16'd10000;
  localparam logic [WIN_W-1:0]  RST_WINDOW        = 16'd1000;
  localparam logic [TS_W-1:0]   RST_FAST_PULSE    = 32'd1000;
  localparam logic [DATA_W-1:0] RST_FAULT_MAP     = 32'h7654_3210;

  // Register index at paddr[4:2]
  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT,
    REG_LOG_EDGES,
    REG_FAULT_EDGES,
    REG_FAULT_HOLD,
    REG_WINDOW,
    REG_FAST_PULSE,
    REG_FAULT_MAP
  } cfg_reg_e;

  // Input operation and output kind codes (tuser)
  localparam logic OP_EDGE        = 1'b0;
  localparam logic OP_TICK        = 1'b1;
  localparam logic KIND_REPORT    = 1'b0;
  localparam logic KIND_SUMMARY   = 1'b1;

  // Shared subtract / compare unit
  typedef struct packed {
    logic [TS_W-1:0] a;
    logic [TS_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TS_W-1:0] diff;  // a - b modulo 2^32
    logic            lt;    // a < b, unsigned
  } alu_rsp_t;

endpackage

// ----- hdl/pcm_alu.sv -----
`timescale 1ns / 1ps

module pcm_alu import pcm_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [TS_W:0] diff_ext;

  // One wide subtract; the borrow is the unsigned less-than
  assign diff_ext   = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.diff = diff_ext[TS_W-1:0];
  assign rsp_o.lt   = diff_ext[TS_W];

endmodule

// ----- hdl/pin_chatter_monitor.sv -----
`timescale 1ns / 1ps

// Pin chatter monitor for up to eight pins.
// Input stream: tuser[0] = 0 for a pin edge (channel, microsecond timestamp),
// 1 for a millisecond tick (pin levels). Edges return nothing; each tick
// returns zero or more channel reports followed by one fault summary beat,
// which carries tlast. Registers are written over the APB port; the user must
// write them only while idle, as the block itself does not enforce it.
// An edge on a channel in use goes through accept, gap subtract and shortest
// compare, all through the one shared 32-bit subtract/compare unit; an edge on
// an unused channel is only accepted. A tick, when the window
// stays open, goes on to its summary beat; when it closes, the scan makes a log
// compare for each quiet channel and, for each reported channel, the log, fault
// and fast compares in the shared unit, then the output load. tready is high
// only between items.
// A finished beat waits in the output register; the block takes the next
// item meanwhile, and a stalled receiver only holds the scan at the next
// beat it must load.
// Reset clears all channel state, the window counter and the output
// register, and loads the register defaults.

module pin_chatter_monitor import pcm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] channel, [34:3] timestamp_us, [42:35] pin_levels, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic [0:0]             s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] report_channel, [26:3] edge_count, [58:27] shortest_us,
  // [59] fast_noise, [60] faulted, [61] pin_level, [77:62] fault_bits, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] kind
  output logic [0:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_GAP,
    ST_EDGE_UPD,
    ST_AGE,
    ST_SCAN_LOG,
    ST_SCAN_FLT,
    ST_SCAN_FAST,
    ST_EMIT,
    ST_SUM
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [NCH_W-1:0]  cfg_nch_q,   cfg_nch_d;
  logic [CNT_W-1:0]  cfg_log_q,   cfg_log_d;
  logic [CNT_W-1:0]  cfg_fault_q, cfg_fault_d;
  logic [HOLD_W-1:0] cfg_hold_q,  cfg_hold_d;
  logic [WIN_W-1:0]  cfg_win_q,   cfg_win_d;
  logic [TS_W-1:0]   cfg_fast_q,  cfg_fast_d;
  logic [DATA_W-1:0] cfg_map_q,   cfg_map_d;

  // Channel state
  logic [CNT_W-1:0]  cnt_q  [NUM_CH];
  logic [CNT_W-1:0]  cnt_d  [NUM_CH];
  logic [TS_W-1:0]   sh_q   [NUM_CH];
  logic [TS_W-1:0]   sh_d   [NUM_CH];
  logic [TS_W-1:0]   last_q [NUM_CH];
  logic [TS_W-1:0]   last_d [NUM_CH];
  logic [HOLD_W-1:0] hold_q [NUM_CH];
  logic [HOLD_W-1:0] hold_d [NUM_CH];
  logic [WIN_W-1:0]  win_q, win_d;

  // Item being worked on
  logic [CH_W-1:0]   ch_q,   ch_d;
  logic [TS_W-1:0]   ts_q,   ts_d;
  logic [LVL_W-1:0]  lvl_q,  lvl_d;
  logic [TS_W-1:0]   gap_q,  gap_d;
  logic [NCH_W-1:0]  scan_q, scan_d;
  logic              flt_q,  flt_d;
  logic              fast_q, fast_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic                   out_kind_q,  out_kind_d;
  logic                   out_last_q,  out_last_d;
  logic [OUT_TDATA_W-1:0] out_data_q,  out_data_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [NCH_W-1:0]  used_n;
  logic [WIN_W-1:0]  win_eff;
  logic [WIN_W-1:0]  win_next;
  logic [CH_W-1:0]   sidx;
  logic [BITS_W-1:0] fault_bits;
  logic              slot_free;
  logic              cfg_wr;
  logic [CH_W-1:0]   in_ch;

  pcm_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign used_n    = (cfg_nch_q > NCH_W'(NUM_CH)) ? NCH_W'(NUM_CH) : cfg_nch_q;
  assign win_eff   = (cfg_win_q == '0) ? WIN_W'(1) : cfg_win_q;
  assign win_next  = win_q + WIN_W'(1);
  assign sidx      = scan_q[CH_W-1:0];
  assign slot_free = !out_valid_q || m_axis_tready;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_ch     = s_axis_tdata[CH_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign pready        = 1'b1;

  // Register readback
  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_CHANNEL_COUNT: prdata = DATA_W'(cfg_nch_q);
      REG_LOG_EDGES:     prdata = DATA_W'(cfg_log_q);
      REG_FAULT_EDGES:   prdata = DATA_W'(cfg_fault_q);
      REG_FAULT_HOLD:    prdata = DATA_W'(cfg_hold_q);
      REG_WINDOW:        prdata = DATA_W'(cfg_win_q);
      REG_FAST_PULSE:    prdata = cfg_fast_q;
      REG_FAULT_MAP:     prdata = cfg_map_q;
      default:           prdata = '0;
    endcase
  end

  // Mapped fault bits of channels in use with a running hold
  always_comb begin
    fault_bits = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if ((NCH_W'(i) < used_n) && (hold_q[i] != '0)) begin
        fault_bits = fault_bits | (BITS_W'(1) << cfg_map_q[MAP_W*i +: MAP_W]);
      end
    end
  end

  // Operand select for the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      ST_EDGE_GAP: begin
        alu_req.a = ts_q;
        alu_req.b = last_q[ch_q];
      end
      ST_EDGE_UPD: begin
        alu_req.a = gap_q;
        alu_req.b = sh_q[ch_q];
      end
      ST_SCAN_LOG: begin
        alu_req.a = TS_W'(cfg_log_q);
        alu_req.b = TS_W'(cnt_q[sidx]);
      end
      ST_SCAN_FLT: begin
        alu_req.a = TS_W'(cfg_fault_q);
        alu_req.b = TS_W'(cnt_q[sidx]);
      end
      ST_SCAN_FAST: begin
        alu_req.a = sh_q[sidx];
        alu_req.b = cfg_fast_q;
      end
      default: alu_req = '0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    cfg_nch_d   = cfg_nch_q;
    cfg_log_d   = cfg_log_q;
    cfg_fault_d = cfg_fault_q;
    cfg_hold_d  = cfg_hold_q;
    cfg_win_d   = cfg_win_q;
    cfg_fast_d  = cfg_fast_q;
    cfg_map_d   = cfg_map_q;
    cnt_d       = cnt_q;
    sh_d        = sh_q;
    last_d      = last_q;
    hold_d      = hold_q;
    win_d       = win_q;
    ch_d        = ch_q;
    ts_d        = ts_q;
    lvl_d       = lvl_q;
    gap_d       = gap_q;
    scan_d      = scan_q;
    flt_d       = flt_q;
    fast_d      = fast_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;

    // Beat taken by the receiver
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // Register writes
    if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_CHANNEL_COUNT: cfg_nch_d   = pwdata[NCH_W-1:0];
        REG_LOG_EDGES:     cfg_log_d   = pwdata[CNT_W-1:0];
        REG_FAULT_EDGES:   cfg_fault_d = pwdata[CNT_W-1:0];
        REG_FAULT_HOLD:    cfg_hold_d  = pwdata[HOLD_W-1:0];
        REG_WINDOW:        cfg_win_d   = pwdata[WIN_W-1:0];
        REG_FAST_PULSE:    cfg_fast_d  = pwdata;
        REG_FAULT_MAP:     cfg_map_d   = pwdata;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ch_d  = in_ch;
          ts_d  = s_axis_tdata[CH_W +: TS_W];
          lvl_d = s_axis_tdata[CH_W+TS_W +: LVL_W];
          if (s_axis_tuser[0] == OP_TICK) begin
            state_d = ST_AGE;
          end else if (NCH_W'(in_ch) < used_n) begin
            state_d = ST_EDGE_GAP;
          end
        end
      end
      ST_EDGE_GAP: begin
        gap_d   = alu_rsp.diff;
        state_d = ST_EDGE_UPD;
      end
      ST_EDGE_UPD: begin
        last_d[ch_q] = ts_q;
        if (cnt_q[ch_q] != COUNT_MAX) begin
          cnt_d[ch_q] = cnt_q[ch_q] + CNT_W'(1);
        end
        if (alu_rsp.lt) begin
          sh_d[ch_q] = gap_q;
        end
        state_d = ST_IDLE;
      end
      ST_AGE: begin
        // Age every hold, then advance the window
        for (int i = 0; i < NUM_CH; i++) begin
          if (hold_q[i] != '0) begin
            hold_d[i] = hold_q[i] - HOLD_W'(1);
          end
        end
        if (win_next >= win_eff) begin
          win_d   = '0;
          scan_d  = '0;
          state_d = ST_SCAN_LOG;
        end else begin
          win_d   = win_next;
          state_d = ST_SUM;
        end
      end
      ST_SCAN_LOG: begin
        if (scan_q >= used_n) begin
          state_d = ST_SUM;
        end else if (alu_rsp.lt) begin
          state_d = ST_SCAN_FLT;
        end else begin
          cnt_d[sidx] = '0;
          sh_d[sidx]  = ALL_ONES;
          scan_d      = scan_q + NCH_W'(1);
        end
      end
      ST_SCAN_FLT: begin
        flt_d   = alu_rsp.lt;
        state_d = ST_SCAN_FAST;
      end
      ST_SCAN_FAST: begin
        fast_d  = alu_rsp.lt;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_REPORT;
          out_last_d  = 1'b0;
          out_data_d  = {2'b00, BITS_W'(0), lvl_q[sidx], flt_q, fast_q,
                         sh_q[sidx], cnt_q[sidx], sidx};
          cnt_d[sidx] = '0;
          sh_d[sidx]  = ALL_ONES;
          if (flt_q) begin
            hold_d[sidx] = cfg_hold_q;
          end
          scan_d  = scan_q + NCH_W'(1);
          state_d = ST_SCAN_LOG;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_SUMMARY;
          out_last_d  = 1'b1;
          out_data_d  = {2'b00, fault_bits, (OUT_TDATA_W-BITS_W-2)'(0)};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, channel store, payload and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_nch_q   <= RST_CHANNEL_COUNT;
      cfg_log_q   <= RST_LOG_EDGES;
      cfg_fault_q <= RST_FAULT_EDGES;
      cfg_hold_q  <= RST_FAULT_HOLD;
      cfg_win_q   <= RST_WINDOW;
      cfg_fast_q  <= RST_FAST_PULSE;
      cfg_map_q   <= RST_FAULT_MAP;
      for (int i = 0; i < NUM_CH; i++) begin
        cnt_q[i]  <= '0;
        sh_q[i]   <= ALL_ONES;
        last_q[i] <= '0;
        hold_q[i] <= '0;
      end
      win_q       <= '0;
      scan_q      <= '0;
      ch_q        <= '0;
      ts_q        <= '0;
      lvl_q       <= '0;
      gap_q       <= '0;
      flt_q       <= 1'b0;
      fast_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_REPORT;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cfg_nch_q   <= cfg_nch_d;
      cfg_log_q   <= cfg_log_d;
      cfg_fault_q <= cfg_fault_d;
      cfg_hold_q  <= cfg_hold_d;
      cfg_win_q   <= cfg_win_d;
      cfg_fast_q  <= cfg_fast_d;
      cfg_map_q   <= cfg_map_d;
      cnt_q       <= cnt_d;
      sh_q        <= sh_d;
      last_q      <= last_d;
      hold_q      <= hold_d;
      win_q       <= win_d;
      scan_q      <= scan_d;
      ch_q        <= ch_d;
      ts_q        <= ts_d;
      lvl_q       <= lvl_d;
      gap_q       <= gap_d;
      flt_q       <= flt_d;
      fast_q      <= fast_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_last_q  <= out_last_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule
